/* src/calendar_time_zone_shift_unit_defines.svh */
// Assertion macros used by the checker of the time zone shift unit.
`ifndef CALENDAR_TIME_ZONE_SHIFT_UNIT_DEFINES_SVH
`define CALENDAR_TIME_ZONE_SHIFT_UNIT_DEFINES_SVH

// Checked only while out of reset.
`define CTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/cts_pkg.sv */
package cts_pkg;

  localparam logic [3:0]  MONTH_JAN  = 4'd1;
  localparam logic [3:0]  MONTH_FEB  = 4'd2;
  localparam logic [3:0]  MONTH_DEC  = 4'd12;
  localparam logic [15:0] YEAR_FLOOR = 16'd2000;
  localparam logic [2:0]  WD_UNKNOWN = 3'd0;
  localparam logic [2:0]  WD_MON     = 3'd1;
  localparam logic [2:0]  WD_SUN     = 3'd7;

  typedef struct packed {
    logic [15:0]        in_year;
    logic [3:0]         in_month;
    logic [4:0]         in_day;
    logic [4:0]         in_hour;
    logic [5:0]         in_minute;
    logic [5:0]         in_second;
    logic [2:0]         in_weekday;
    logic signed [11:0] shift_minutes;
  } cts_in_t;

  typedef struct packed {
    logic [15:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
    logic [2:0]  out_weekday;
  } cts_out_t;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
  } cts_date_t;

  // Days in a month; months outside 1..12 count as 30 days.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      MONTH_FEB:                   len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:     len = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:          len = 5'd31;
      default:                     len = 5'd30;
    endcase
    return len;
  endfunction

  function automatic cts_date_t step_fwd(input cts_date_t dt, input logic leap);
    cts_date_t r;
    r = dt;
    if (dt.day < month_len(dt.month, leap)) begin
      r.day = dt.day + 5'd1;
    end else begin
      r.day = 5'd1;
      if (dt.month < MONTH_DEC) begin
        r.month = dt.month + 4'd1;
      end else begin
        r.month = MONTH_JAN;
        r.year  = dt.year + 16'd1;
      end
    end
    if (dt.weekday != WD_UNKNOWN) begin
      r.weekday = (dt.weekday == WD_SUN) ? WD_MON : dt.weekday + 3'd1;
    end
    return r;
  endfunction

  function automatic cts_date_t step_back(input cts_date_t dt, input logic leap);
    cts_date_t r;
    r = dt;
    if (dt.day > 5'd1) begin
      r.day = dt.day - 5'd1;
    end else begin
      if (dt.month > MONTH_JAN) begin
        r.month = dt.month - 4'd1;
      end else begin
        r.month = MONTH_DEC;
        if (dt.year > YEAR_FLOOR) begin
          r.year = dt.year - 16'd1;
        end
      end
      r.day = month_len(r.month, leap);
    end
    if (dt.weekday != WD_UNKNOWN) begin
      r.weekday = (dt.weekday == WD_MON) ? WD_SUN : dt.weekday - 3'd1;
    end
    return r;
  endfunction

endpackage

/* src/calendar_time_zone_shift_unit.sv */
// The edge that accepts an item loads the input register; the result register
// then loads from it once it is free, which raises out_valid.
// Throughput: one item per cycle; while a result waits the input register
// holds its item, and in_ready follows out_ready through it.
// Reset (rst_n low, synchronous) empties both registers; payload is not reset.
module calendar_time_zone_shift_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  cts_pkg::cts_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output cts_pkg::cts_out_t out_data
);
  import cts_pkg::*;

  localparam logic signed [12:0] DAY_MIN     = 13'sd1440;
  localparam logic signed [12:0] TWO_DAY_MIN = 13'sd2880;
  // y / 100 as (y * 83887) >> 23, exact over 16 bits.
  localparam logic [32:0] RECIP_100 = 33'd83887;
  // m / 60 as (m * 2185) >> 17, exact for m below 1440.
  localparam logic [22:0] RECIP_60  = 23'd2185;

  logic     a_v_r;
  cts_in_t  a_r;
  logic     out_v_r;
  cts_out_t out_r;
  cts_out_t out_nxt;

  logic out_free;
  logic a_free;

  // Each register takes a new item when it is empty or its item moves on.
  assign out_free = !out_v_r || out_ready;
  assign a_free   = !a_v_r || out_free;
  assign in_ready = a_free;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // ---- minute of day, day count, leap year, day steps ----
  logic [10:0]        a_hm;
  logic signed [12:0] a_tot;
  logic signed [12:0] a_mod;
  logic               a_move;
  logic               a_back;
  logic               a_two;
  logic [32:0]        a_prod;
  logic [9:0]         a_q;
  logic               a_div100;
  logic               a_leap;
  cts_date_t          a_date;
  cts_date_t          a_d1;
  cts_date_t          a_d2;
  logic [22:0]        a_mprod;
  logic [4:0]         a_hour;
  logic [10:0]        a_rem;

  always_comb begin
    a_hm  = 11'({6'd0, a_r.in_hour} * 11'd60) + {5'd0, a_r.in_minute};
    a_tot = $signed({2'b00, a_hm}) +
            $signed({a_r.shift_minutes[11], a_r.shift_minutes});

    // The sum spans -2048..3970, so at most two days either way.
    if (a_tot < -DAY_MIN) begin
      a_move = 1'b1; a_back = 1'b1; a_two = 1'b1;
      a_mod  = a_tot + TWO_DAY_MIN;
    end else if (a_tot < 13'sd0) begin
      a_move = 1'b1; a_back = 1'b1; a_two = 1'b0;
      a_mod  = a_tot + DAY_MIN;
    end else if (a_tot >= TWO_DAY_MIN) begin
      a_move = 1'b1; a_back = 1'b0; a_two = 1'b1;
      a_mod  = a_tot - TWO_DAY_MIN;
    end else if (a_tot >= DAY_MIN) begin
      a_move = 1'b1; a_back = 1'b0; a_two = 1'b0;
      a_mod  = a_tot - DAY_MIN;
    end else begin
      a_move = 1'b0; a_back = 1'b0; a_two = 1'b0;
      a_mod  = a_tot;
    end

    // Leap test of the input year. That year is the only one whose February
    // can be reached: a year change always lands on December or January.
    // Divisible by 100 exactly when the fraction bits stay below the factor.
    a_prod   = {17'd0, a_r.in_year} * RECIP_100;
    a_q      = a_prod[32:23];
    a_div100 = (a_prod[22:0] < RECIP_100[22:0]);
    a_leap   = (a_r.in_year[1:0] == 2'b00) && (!a_div100 || (a_q[1:0] == 2'b00));

    a_date.year    = a_r.in_year;
    a_date.month   = a_r.in_month;
    a_date.day     = a_r.in_day;
    a_date.weekday = a_r.in_weekday;

    a_d1 = a_back ? step_back(a_date, a_leap) : step_fwd(a_date, a_leap);
    a_d2 = a_back ? step_back(a_d1, a_leap) : step_fwd(a_d1, a_leap);

    // Hour and minute of the new day.
    a_mprod = {12'd0, a_mod[10:0]} * RECIP_60;
    a_hour  = a_mprod[21:17];
    a_rem   = a_mod[10:0] - 11'({6'd0, a_hour} * 11'd60);

    if (!a_move) begin
      out_nxt.out_year    = a_date.year;
      out_nxt.out_month   = a_date.month;
      out_nxt.out_day     = a_date.day;
      out_nxt.out_weekday = a_date.weekday;
    end else if (a_two) begin
      out_nxt.out_year    = a_d2.year;
      out_nxt.out_month   = a_d2.month;
      out_nxt.out_day     = a_d2.day;
      out_nxt.out_weekday = a_d2.weekday;
    end else begin
      out_nxt.out_year    = a_d1.year;
      out_nxt.out_month   = a_d1.month;
      out_nxt.out_day     = a_d1.day;
      out_nxt.out_weekday = a_d1.weekday;
    end
    out_nxt.out_hour   = a_hour;
    out_nxt.out_minute = a_rem[5:0];
    out_nxt.out_second = a_r.in_second;
  end

  // ---- input and result registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (a_free) begin
        a_v_r <= in_valid;
      end
      if (out_free) begin
        out_v_r <= a_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_free && in_valid) begin
      a_r <= in_data;
    end
    if (out_free && a_v_r) begin
      out_r <= out_nxt;
    end
  end

endmodule

/* src/cts_checker.sv */
`include "calendar_time_zone_shift_unit_defines.svh"

module cts_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input cts_pkg::cts_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input cts_pkg::cts_out_t out_data
);
  import cts_pkg::*;

  `CTS_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "output valid after reset")
  `CTS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled item changed")
  `CTS_ASSERT(a_time_range, out_valid |-> (out_data.out_hour < 5'd24) && (out_data.out_minute < 6'd60), "hour or minute out of range")
  `CTS_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input blocked with empty output")
  `CTS_ASSERT(a_latency, (in_valid && in_ready) ##1 out_ready |=> out_valid, "item not delivered in time")

endmodule

bind calendar_time_zone_shift_unit cts_checker u_cts_checker (.*);

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;
  import cts_pkg::*;

  localparam int CLK_HALF        = 10;
  localparam int RESET_CYCLES    = 7;
  // Hard stop far beyond the slowest legal run.
  localparam int CYCLE_LIMIT     = 200000;
  // Block is two registers deep; give a few extra edges after the last result.
  localparam int SETTLE_CYCLES   = 10;
  localparam int LONG_HOLD       = 60;
  localparam int MINUTES_PER_DAY = 1440;
  localparam int MINUTES_PER_HR  = 60;
  localparam int ODD_MONTH_DAYS  = 30;
  localparam int LEAP_FEB_DAYS   = 29;
  localparam int unsigned DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30,
                                                 31, 31, 30, 31, 30, 31};

  typedef enum {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC, SINK_SPARSE} sink_mode_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  cts_in_t   in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  cts_out_t  out_data;

  // Expected shifted date-times, oldest first.
  cts_out_t   local_time_q[$];
  sink_mode_t sink_mode     = SINK_OPEN;
  int         sink_hold_len = 0;

  int cycle_count      = 0;
  int items_sent       = 0;
  int directed_items   = 0;
  int results_checked  = 0;
  int bad_results      = 0;
  int field_errors     = 0;
  int unexpected_count = 0;
  int input_stalls     = 0;

  calendar_time_zone_shift_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_leap(input int unsigned yr);
    return ((yr % 4) == 0) && (((yr % 100) != 0) || ((yr % 400) == 0));
  endfunction

  // Out-of-range months (0, 13..15) count as 30 days.
  function automatic int unsigned month_span(input int unsigned yr, input int unsigned mo);
    if (mo == MONTH_FEB && is_leap(yr)) return LEAP_FEB_DAYS;
    if (mo >= MONTH_JAN && mo <= MONTH_DEC) return DAYS_IN_MONTH[mo - 1];
    return ODD_MONTH_DAYS;
  endfunction

  function automatic void roll_day_forward(inout int unsigned yr, inout int unsigned mo,
                                           inout int unsigned dy, inout int unsigned wd);
    if (dy < month_span(yr, mo)) begin
      dy++;
    end else begin
      dy = 1;
      if (mo < MONTH_DEC) begin
        mo++;
      end else begin
        mo = MONTH_JAN;
        yr = (yr + 1) & 16'hFFFF;
      end
    end
    if (wd != WD_UNKNOWN) wd = (wd == WD_SUN) ? WD_MON : wd + 1;
  endfunction

  // Borrow: year is floored at 2000, day length taken from the new month/year.
  function automatic void roll_day_back(inout int unsigned yr, inout int unsigned mo,
                                        inout int unsigned dy, inout int unsigned wd);
    if (dy > 1) begin
      dy--;
    end else begin
      if (mo > MONTH_JAN) begin
        mo--;
      end else begin
        mo = MONTH_DEC;
        if (yr > YEAR_FLOOR) yr--;
      end
      dy = month_span(yr, mo);
    end
    if (wd != WD_UNKNOWN) wd = (wd == WD_MON) ? WD_SUN : wd - 1;
  endfunction

  function automatic cts_out_t predict_local_time(input cts_in_t src);
    cts_out_t    res;
    int unsigned yr, mo, dy, wd;
    int          day_min;
    yr = src.in_year;
    mo = src.in_month;
    dy = src.in_day;
    wd = src.in_weekday;
    // Hour and minute at full field width, offset as 12-bit two's complement.
    day_min = int'(src.in_hour) * MINUTES_PER_HR + int'(src.in_minute)
            + int'($signed(src.shift_minutes));
    while (day_min < 0) begin
      day_min += MINUTES_PER_DAY;
      roll_day_back(yr, mo, dy, wd);
    end
    while (day_min >= MINUTES_PER_DAY) begin
      day_min -= MINUTES_PER_DAY;
      roll_day_forward(yr, mo, dy, wd);
    end
    res.out_year    = 16'(yr);
    res.out_month   = 4'(mo);
    res.out_day     = 5'(dy);
    res.out_hour    = 5'(day_min / MINUTES_PER_HR);
    res.out_minute  = 6'(day_min % MINUTES_PER_HR);
    res.out_second  = src.in_second;
    res.out_weekday = 3'(wd);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic cts_in_t make_stamp(input int yr, input int mo, input int dy,
                                         input int hr, input int mi, input int sec,
                                         input int wd, input int shift);
    cts_in_t s;
    s.in_year       = 16'(yr);
    s.in_month      = 4'(mo);
    s.in_day        = 5'(dy);
    s.in_hour       = 5'(hr);
    s.in_minute     = 6'(mi);
    s.in_second     = 6'(sec);
    s.in_weekday    = 3'(wd);
    s.shift_minutes = 12'(shift);
    return s;
  endfunction

  // Mostly legal date-times with a bias toward month/year edges and offsets
  // that just cross midnight; some fully random fields for the odd corners.
  function automatic cts_in_t random_stamp();
    int yr, mo, dy, hr, mi, span, shift, now;
    case ($urandom_range(0, 7))
      0:       yr = $urandom_range(0, 65535);
      1:       yr = $urandom_range(65533, 65535);
      2:       yr = $urandom_range(1998, 2002);
      3:       yr = 100 * $urandom_range(16, 30) - $urandom_range(0, 1);
      default: yr = $urandom_range(1970, 2099);
    endcase
    mo   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
    span = month_span(yr, mo);
    case ($urandom_range(0, 5))
      0:       dy = $urandom_range(0, 31);
      1:       dy = 1;
      2:       dy = span;
      3:       dy = span - 1;
      default: dy = $urandom_range(1, span);
    endcase
    hr  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 23);
    mi  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 59);
    now = hr * MINUTES_PER_HR + mi;
    case ($urandom_range(0, 7))
      0:       shift = int'($urandom_range(0, 4095)) - 2048;
      1:       shift = -now - 1 + int'($urandom_range(0, 2));
      2:       shift = MINUTES_PER_DAY - now - 1 + int'($urandom_range(0, 2));
      default: shift = int'($urandom_range(0, 2 * MINUTES_PER_DAY)) - MINUTES_PER_DAY;
    endcase
    return make_stamp(yr, mo, dy, hr, mi, $urandom_range(0, 63), $urandom_range(0, 7), shift);
  endfunction

  // Called at a rising edge; returns at the edge that accepts the item with
  // in_valid still high, so back-to-back calls keep the channel busy.
  task automatic send_stamp(input cts_in_t stamp);
    in_data  <= stamp;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    local_time_q.push_back(predict_local_time(stamp));
    items_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Sender goes quiet until every expected result has come back.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (local_time_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_calendar_corners();
    cts_in_t corner [$];
    sink_mode = SINK_OPEN;
    corner.push_back(make_stamp(2024,  3, 15, 12, 30, 45, 5,     0)); // no move
    corner.push_back(make_stamp(2023,  1, 31, 23, 30,  0, 2,    60)); // 31-day month end
    corner.push_back(make_stamp(2024,  2, 28, 23,  0, 10, 3,   120)); // leap Feb 29
    corner.push_back(make_stamp(2023,  2, 28, 23,  0, 10, 2,    61)); // plain Feb end
    corner.push_back(make_stamp(2100,  2, 28,  6,  0,  0, 7,  1440)); // century, Sun->Mon
    corner.push_back(make_stamp(2000,  2, 28, 22,  0,  0, 1,   180)); // div-by-400 leap
    corner.push_back(make_stamp(65535, 12, 31, 23, 59, 59, 7,    1)); // year wraps to 0
    corner.push_back(make_stamp(2024,  1,  1,  0,  0,  0, 1,    -1)); // back a year, Mon->Sun
    corner.push_back(make_stamp(2000,  1,  1,  0, 10,  0, 6,   -20)); // year floor held
    corner.push_back(make_stamp(0,     1,  1,  0,  0,  0, 0, -1440)); // below floor, weekday 0
    corner.push_back(make_stamp(2024,  3,  1,  0,  0,  0, 5, -1440)); // back into leap Feb
    corner.push_back(make_stamp(2023,  3,  1,  0, 30,  0, 3,   -31)); // back into Feb 28
    corner.push_back(make_stamp(2023,  0, 30, 23,  0,  0, 4,    60)); // month 0 forward
    corner.push_back(make_stamp(2023,  0,  1,  0,  0,  0, 4,   -60)); // month 0 back
    corner.push_back(make_stamp(2023, 15, 30, 23, 59,  0, 2,     1)); // month 15 -> next Jan
    corner.push_back(make_stamp(2023, 14,  1,  1,  0,  0, 2,  -120)); // month 14 -> 13/30
    corner.push_back(make_stamp(2023, 13, 31, 12,  0,  0, 0,   720)); // day past 30-day end
    corner.push_back(make_stamp(2024,  4,  0,  0,  0,  0, 3,    -1)); // day 0 back
    corner.push_back(make_stamp(2024,  4,  0, 23,  0,  0, 3,    60)); // day 0 forward
    corner.push_back(make_stamp(2024, 12, 31, 31, 63, 63, 7,  2047)); // two days forward
    corner.push_back(make_stamp(2024,  1,  1,  0,  0, 63, 1, -2048)); // two days back
    corner.push_back(make_stamp(2024,  6, 30,  0,  0,  0, 6, -1440)); // exactly one day back
    corner.push_back(make_stamp(2024,  6, 30,  0,  0,  0, 6,  1440)); // exactly one day on
    corner.push_back(make_stamp(21845, 10, 21, 21, 42, 21, 5, -1366)); // 0101.. pattern
    corner.push_back(make_stamp(43690,  5, 10, 10, 21, 42, 2,  1365)); // 1010.. pattern
    foreach (corner[i]) send_stamp(corner[i]);
    directed_items = corner.size();
    wait_results_drained();
  endtask

  // Full rate both ways, no idling at all.
  task automatic test_steady_stream(input int count);
    sink_mode = SINK_OPEN;
    repeat (count) send_stamp(random_stamp());
    wait_results_drained();
  endtask

  // Result side holds off long enough for the block to fill and push back
  // on the input while the sender keeps offering items.
  task automatic test_backpressure_fill(input int count);
    sink_mode     = SINK_OPEN;
    sink_hold_len = LONG_HOLD;
    repeat (count) send_stamp(random_stamp());
    wait_results_drained();
  endtask

  // Bursts of random length, random gaps, receiver pacing set by mode.
  task automatic test_bursty_traffic(input sink_mode_t mode, input int count);
    int sent, burst;
    sink_mode = mode;
    sent      = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && sent < count; k++) begin
        send_stamp(random_stamp());
        sent++;
      end
      pause_sender($urandom_range(0, 5));
    end
    wait_results_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver pacing: one assignment of out_ready per edge. A pending hold
  // count takes priority and is counted down here, cycle by cycle.
  // ---------------------------------------------------------------------------
  initial begin : sink_pacing
    int phase;
    phase = 0;
    forever begin
      @(posedge clk);
      phase = (phase + 1) % 7;
      if (sink_hold_len > 0) begin
        out_ready <= 1'b0;
        sink_hold_len--;
      end else begin
        case (sink_mode)
          SINK_OPEN:     out_ready <= 1'b1;
          SINK_RANDOM:   out_ready <= 1'($urandom_range(0, 1));
          SINK_PERIODIC: out_ready <= (phase >= 2);       // low while phase is 0 or 1
          default:       out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: values sampled at the edge are the pre-edge ones, since
  // everything on both sides is updated by nonblocking assignment.
  // ---------------------------------------------------------------------------
  function automatic bit field_ok(input string label, input int unsigned want,
                                  input int unsigned got);
    if (want == got) return 1'b1;
    field_errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
    return 1'b0;
  endfunction

  always @(posedge clk) begin : result_check
    cts_out_t want;
    bit       ok;
    if (rst_n && out_valid && out_ready) begin
      if (local_time_q.size() == 0) begin
        unexpected_count++;
        $display("%0t: result with nothing expected, expected none, actual %h",
                 $time, out_data);
      end else begin
        want = local_time_q.pop_front();
        ok   = 1'b1;
        ok  &= field_ok("out_year",    want.out_year,    out_data.out_year);
        ok  &= field_ok("out_month",   want.out_month,   out_data.out_month);
        ok  &= field_ok("out_day",     want.out_day,     out_data.out_day);
        ok  &= field_ok("out_hour",    want.out_hour,    out_data.out_hour);
        ok  &= field_ok("out_minute",  want.out_minute,  out_data.out_minute);
        ok  &= field_ok("out_second",  want.out_second,  out_data.out_second);
        ok  &= field_ok("out_weekday", want.out_weekday, out_data.out_weekday);
        if (!ok) bad_results++;
        results_checked++;
      end
    end
  end

  // Cycle count, input backpressure count, and the run's hard stop.
  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && in_valid && !in_ready) input_stalls++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, local_time_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_sequence
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_calendar_corners();
    test_steady_stream(200);
    test_backpressure_fill(40);
    test_bursty_traffic(SINK_RANDOM, 250);
    test_bursty_traffic(SINK_PERIODIC, 220);
    test_bursty_traffic(SINK_SPARSE, 200);
    test_bursty_traffic(SINK_RANDOM, 220);

    // Anything arriving now would be a result without an item behind it.
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Shifted %0d date-times (%0d corner cases), checked %0d results, %0d bad fields",
             items_sent, directed_items, results_checked, field_errors);
    $display("Input was held off for %0d cycles; %0d unexpected results",
             input_stalls, unexpected_count);
    if (bad_results == 0 && unexpected_count == 0 && local_time_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* calendar_time_zone_shift_unit.f */
+incdir+src
src/cts_pkg.sv
src/calendar_time_zone_shift_unit.sv
src/cts_checker.sv
test/tb.sv
